FILE: design/trs_pkg.sv
// Shared types, constants and arithmetic helpers for the model matrix composer
package trs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_BITS  = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int CW          = 34;  // cordic datapath width, Q2.30 plus headroom
  localparam int ZW          = 33;  // residual angle width
  localparam int PW          = 32;  // phase width
  localparam int MW          = 33;  // rotation element width (Q2.30, |v| <= ~2)

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } out_item_t;

  // One cordic lane: x, y, residual z and quadrant
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
  } lane_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    lane_t lz;
  } cell_data_t;

  function automatic logic signed [ZW-1:0] atan_of(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      default: t = 32'h00000005;
    endcase
    return ZW'(t);
  endfunction

  // Round a Q2.30 x Q2.30 product back to Q2.30
  function automatic logic signed [MW-1:0] mul_q30(input logic signed [MW-1:0] a,
                                                   input logic signed [MW-1:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'(HALF_Q30);
    return MW'(p >>> 30);
  endfunction

  // Load a lane from an angle: split quadrant, keep signed remainder
  function automatic lane_t lane_load(input logic [15:0] angle);
    logic [PW-1:0] phase;
    logic [PW-1:0] sum;
    lane_t l;
    phase = PW'(angle[ANGLE_BITS-1:0]) << (PW - ANGLE_BITS);
    sum   = phase + 32'h20000000;
    l.q   = sum[31:30];
    l.x   = CORDIC_X0;
    l.y   = '0;
    l.z   = ZW'($signed(phase - {l.q, 30'd0}));
    return l;
  endfunction

endpackage

FILE: design/trs_cordic_cell.sv
// One CORDIC rotation step for three angle lanes, registered
module trs_cordic_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [4:0]              step,
  input  logic                    vld_in,
  input  trs_pkg::cell_data_t     d_in,
  input  trs_pkg::in_item_t       item_in,
  output logic                    vld_out,
  output trs_pkg::cell_data_t     d_out,
  output trs_pkg::in_item_t       item_out
);

  logic                vld_r;
  trs_pkg::cell_data_t d_r, d_nxt;
  trs_pkg::in_item_t   item_r;

  function automatic trs_pkg::lane_t rot(input trs_pkg::lane_t l, input logic [4:0] s);
    trs_pkg::lane_t o;
    logic signed [trs_pkg::ZW-1:0] a;
    a = trs_pkg::atan_of(int'(s));
    o.q = l.q;
    if (!l.z[trs_pkg::ZW-1]) begin
      o.x = l.x - (l.y >>> s);
      o.y = l.y + (l.x >>> s);
      o.z = l.z - a;
    end else begin
      o.x = l.x + (l.y >>> s);
      o.y = l.y - (l.x >>> s);
      o.z = l.z + a;
    end
    return o;
  endfunction

  always_comb begin
    d_nxt.lx = rot(d_in.lx, step);
    d_nxt.ly = rot(d_in.ly, step);
    d_nxt.lz = rot(d_in.lz, step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    d_r    <= d_nxt;
    item_r <= item_in;
  end

  assign vld_out  = vld_r;
  assign d_out    = d_r;
  assign item_out = item_r;

endmodule

FILE: design/trs_compose.sv
// Matrix assembly: quadrant fix-up, rotation products, scaling and saturation
module trs_compose (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  trs_pkg::cell_data_t d_in,
  input  trs_pkg::in_item_t   item_in,
  output logic                vld_out,
  output trs_pkg::out_item_t  res_out
);

  localparam int MW = trs_pkg::MW;
  typedef logic signed [MW-1:0] el_t;

  function automatic void fix(input trs_pkg::lane_t l, output el_t c, output el_t s);
    el_t x, y;
    x = MW'(l.x);
    y = MW'(l.y);
    case (l.q)
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] sat(input el_t e, input logic signed [31:0] k);
    logic signed [65:0] p;
    p = (66'(e) * 66'(k) + 66'(trs_pkg::HALF_Q30)) >>> 30;
    if (p > 66'sd2147483647) return 32'h7FFFFFFF;
    if (p < -66'sd2147483648) return 32'h80000000;
    return p[31:0];
  endfunction

  // stage 1: sines/cosines and first products
  logic s1_vld_r;
  el_t cx_r, sx_r, cy_r, sy_r, cz_r, sz_r, sxsz_r, sxcz_r;
  trs_pkg::in_item_t it1_r;
  el_t cx, sx, cy, sy, cz, sz;

  always_comb begin
    fix(d_in.lx, cx, sx);
    fix(d_in.ly, cy, sy);
    fix(d_in.lz, cz, sz);
  end

  // stage 2: pair products
  logic s2_vld_r;
  el_t p_cycz_r, p_sysxsz_r, p_sysxcz_r, p_cysz_r, p_sycx_r, p_cxsz_r, p_cxcz_r;
  el_t p_cysxsz_r, p_sycz_r, p_sysz_r, p_cysxcz_r, p_cycx_r, nsx_r;
  trs_pkg::in_item_t it2_r;

  // stage 3: sums
  logic s3_vld_r;
  el_t m_r [9];
  trs_pkg::in_item_t it3_r;

  // stage 4: scale and saturate
  logic s4_vld_r;
  trs_pkg::out_item_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_in;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    cx_r <= cx; sx_r <= sx; cy_r <= cy; sy_r <= sy; cz_r <= cz; sz_r <= sz;
    sxsz_r <= trs_pkg::mul_q30(sx, sz);
    sxcz_r <= trs_pkg::mul_q30(sx, cz);
    it1_r  <= item_in;

    p_cycz_r   <= trs_pkg::mul_q30(cy_r, cz_r);
    p_sysxsz_r <= trs_pkg::mul_q30(sy_r, sxsz_r);
    p_sysxcz_r <= trs_pkg::mul_q30(sy_r, sxcz_r);
    p_cysz_r   <= trs_pkg::mul_q30(cy_r, sz_r);
    p_sycx_r   <= trs_pkg::mul_q30(sy_r, cx_r);
    p_cxsz_r   <= trs_pkg::mul_q30(cx_r, sz_r);
    p_cxcz_r   <= trs_pkg::mul_q30(cx_r, cz_r);
    p_cysxsz_r <= trs_pkg::mul_q30(cy_r, sxsz_r);
    p_sycz_r   <= trs_pkg::mul_q30(sy_r, cz_r);
    p_sysz_r   <= trs_pkg::mul_q30(sy_r, sz_r);
    p_cysxcz_r <= trs_pkg::mul_q30(cy_r, sxcz_r);
    p_cycx_r   <= trs_pkg::mul_q30(cy_r, cx_r);
    nsx_r      <= -sx_r;
    it2_r      <= it1_r;

    m_r[0] <= p_cycz_r + p_sysxsz_r;
    m_r[1] <= p_sysxcz_r - p_cysz_r;
    m_r[2] <= p_sycx_r;
    m_r[3] <= p_cxsz_r;
    m_r[4] <= p_cxcz_r;
    m_r[5] <= nsx_r;
    m_r[6] <= p_cysxsz_r - p_sycz_r;
    m_r[7] <= p_sysz_r + p_cysxcz_r;
    m_r[8] <= p_cycx_r;
    it3_r  <= it2_r;

    res_r.col0_x  <= sat(m_r[0], it3_r.scale_x);
    res_r.col0_y  <= sat(m_r[3], it3_r.scale_x);
    res_r.col0_z  <= sat(m_r[6], it3_r.scale_x);
    res_r.col1_x  <= sat(m_r[1], it3_r.scale_y);
    res_r.col1_y  <= sat(m_r[4], it3_r.scale_y);
    res_r.col1_z  <= sat(m_r[7], it3_r.scale_y);
    res_r.col2_x  <= sat(m_r[2], it3_r.scale_z);
    res_r.col2_y  <= sat(m_r[5], it3_r.scale_z);
    res_r.col2_z  <= sat(m_r[8], it3_r.scale_z);
    res_r.trans_x <= it3_r.pos_x;
    res_r.trans_y <= it3_r.pos_y;
    res_r.trans_z <= it3_r.pos_z;
  end

  assign vld_out = s4_vld_r;
  assign res_out = res_r;

endmodule

FILE: design/trs_model_matrix_compose_core.sv
// Top level: 28-cell CORDIC chain followed by the matrix assembly pipeline
// An accepted start runs through the load stage, the cell chain and the compose pipeline.
// Throughput: one transaction per cycle; busy is never raised.
// Each cell performs one rotation step for all three angles per cycle.
// Synchronous active-low reset clears the valid chain; no result is in flight after it.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module trs_model_matrix_compose_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  trs_pkg::in_item_t  in_item,
  output logic               out_valid,
  output trs_pkg::out_item_t out_item
);

  localparam int N = trs_pkg::CORDIC_STEPS;

  logic                vld_r;
  trs_pkg::cell_data_t d_r;
  trs_pkg::in_item_t   item_r;

  logic                vc [N+1];
  trs_pkg::cell_data_t dc [N+1];
  trs_pkg::in_item_t   ic [N+1];

  assign busy = 1'b0;

  // load stage: split quadrants
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
    d_r.lx <= trs_pkg::lane_load(in_item.angle_x);
    d_r.ly <= trs_pkg::lane_load(in_item.angle_y);
    d_r.lz <= trs_pkg::lane_load(in_item.angle_z);
    item_r <= in_item;
  end

  assign vc[0] = vld_r;
  assign dc[0] = d_r;
  assign ic[0] = item_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    trs_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (5'(g)),
      .vld_in  (vc[g]),
      .d_in    (dc[g]),
      .item_in (ic[g]),
      .vld_out (vc[g+1]),
      .d_out   (dc[g+1]),
      .item_out(ic[g+1])
    );
  end

  trs_compose u_compose (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vc[N]),
    .d_in    (dc[N]),
    .item_in (ic[N]),
    .vld_out (out_valid),
    .res_out (out_item)
  );

  property p_latency;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##33 out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("result strobe missing");

  property p_no_spurious;
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(start, 33);
  endproperty
  a_no_spurious: assert property (p_no_spurious) else $error("unexpected result");

  property p_trans;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> out_item.trans_x == $past(in_item.pos_x, 33);
  endproperty
  a_trans: assert property (p_trans) else $error("translation mismatch");

endmodule

FILE: sim/trs_matrix_checker.sv
// Checker for the model matrix composer: predicts each matrix and compares results
`timescale 1ns / 1ps

module trs_matrix_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  trs_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  trs_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending_count
);

  trs_pkg::out_item_t pending_matrices[$];

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(input longint a, input longint b);
    return shr_floor(a * b + 64'sd536870912, 30);
  endfunction

  function automatic longint arctan_step(input int i);
    longint tab [28] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005};
    return tab[i];
  endfunction

  task automatic angle_to_trig(input logic [15:0] angle, output longint c,
                               output longint s);
    logic [31:0] phase;
    logic [31:0] rem;
    logic [1:0]  quad;
    longint x, y, z, nx;
    phase = {angle, 16'd0};
    quad = 2'((phase + 32'h20000000) >> 30);
    rem = phase - {quad, 30'd0};
    z = longint'($signed(rem));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= arctan_step(i);
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += arctan_step(i);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [31:0] scale_clip(input longint e, input longint k);
    longint v;
    v = round_q30(e, k);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  task automatic compose_matrix(input trs_pkg::in_item_t it, output trs_pkg::out_item_t m);
    longint cx, sx, cy, sy, cz, sz, sxsz, sxcz;
    longint r[3][3];
    angle_to_trig(it.angle_x, cx, sx);
    angle_to_trig(it.angle_y, cy, sy);
    angle_to_trig(it.angle_z, cz, sz);
    sxsz = round_q30(sx, sz);
    sxcz = round_q30(sx, cz);
    r[0][0] = round_q30(cy, cz) + round_q30(sy, sxsz);
    r[0][1] = round_q30(sy, sxcz) - round_q30(cy, sz);
    r[0][2] = round_q30(sy, cx);
    r[1][0] = round_q30(cx, sz);
    r[1][1] = round_q30(cx, cz);
    r[1][2] = -sx;
    r[2][0] = round_q30(cy, sxsz) - round_q30(sy, cz);
    r[2][1] = round_q30(sy, sz) + round_q30(cy, sxcz);
    r[2][2] = round_q30(cy, cx);
    m.col0_x = scale_clip(r[0][0], it.scale_x);
    m.col0_y = scale_clip(r[1][0], it.scale_x);
    m.col0_z = scale_clip(r[2][0], it.scale_x);
    m.col1_x = scale_clip(r[0][1], it.scale_y);
    m.col1_y = scale_clip(r[1][1], it.scale_y);
    m.col1_z = scale_clip(r[2][1], it.scale_y);
    m.col2_x = scale_clip(r[0][2], it.scale_z);
    m.col2_y = scale_clip(r[1][2], it.scale_z);
    m.col2_z = scale_clip(r[2][2], it.scale_z);
    m.trans_x = it.pos_x;
    m.trans_y = it.pos_y;
    m.trans_z = it.pos_z;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = pending_matrices.size();

  always @(posedge clk) begin
    trs_pkg::out_item_t m;
    trs_pkg::out_item_t e;
    if (!rst_n) begin
      fail_count = 0;
    end
    if (rst_n && out_valid) begin
      if (pending_matrices.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        e = pending_matrices.pop_front();
        check_field("col0_x", e.col0_x, out_item.col0_x);
        check_field("col0_y", e.col0_y, out_item.col0_y);
        check_field("col0_z", e.col0_z, out_item.col0_z);
        check_field("col1_x", e.col1_x, out_item.col1_x);
        check_field("col1_y", e.col1_y, out_item.col1_y);
        check_field("col1_z", e.col1_z, out_item.col1_z);
        check_field("col2_x", e.col2_x, out_item.col2_x);
        check_field("col2_y", e.col2_y, out_item.col2_y);
        check_field("col2_z", e.col2_z, out_item.col2_z);
        check_field("trans_x", e.trans_x, out_item.trans_x);
        check_field("trans_y", e.trans_y, out_item.trans_y);
        check_field("trans_z", e.trans_z, out_item.trans_z);
      end
    end
    if (rst_n && start && !busy) begin
      compose_matrix(in_item, m);
      // append the predicted matrix at the tail
      pending_matrices = {pending_matrices, m};
    end
  end
endmodule

FILE: sim/trs_model_matrix_compose_core_tb.sv
// Testbench top for the model matrix composer: stimulus and verdict
`timescale 1ns / 1ps

module trs_model_matrix_compose_core_tb;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  trs_pkg::in_item_t  in_item;
  logic               out_valid;
  trs_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending_count;
  int                 sender_idle_pct;

  trs_model_matrix_compose_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  trs_matrix_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3) * 16384);
      1: return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one transaction, holding start until it is accepted
  task automatic send_transform(input trs_pkg::in_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic trs_pkg::in_item_t random_transform();
    trs_pkg::in_item_t it;
    it.pos_x = pick_word();
    it.pos_y = pick_word();
    it.pos_z = pick_word();
    it.angle_x = pick_angle();
    it.angle_y = pick_angle();
    it.angle_z = pick_angle();
    it.scale_x = pick_word();
    it.scale_y = pick_word();
    it.scale_z = pick_word();
    return it;
  endfunction

  initial begin
    trs_pkg::in_item_t it;
    int wait_cycles;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    sender_idle_pct = 23;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: identity, axis and mixed turns, extreme scales, positions
    for (int d = 0; d < 20; d++) begin
      it = '0;
      it.scale_x = 32'sh0001_0000;
      it.scale_y = 32'sh0001_0000;
      it.scale_z = 32'sh0001_0000;
      case (d % 5)
        1: it.angle_x = 16'(d * 16384);
        2: it.angle_y = 16'(d * 16384 + 8192);
        3: it.angle_z = 16'(d * 16384 - 1);
        4: begin
          it.angle_x = 16'hFFFF; it.angle_y = 16'h8000; it.angle_z = 16'h4001;
        end
        default: ;
      endcase
      if (d >= 10) begin
        it.scale_x = (d & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        it.scale_y = (d & 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        it.scale_z = (d & 4) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        it.pos_x = 32'sh8000_0000;
        it.pos_y = 32'sh7FFF_FFFF;
        it.pos_z = 32'hFFFF_FFFF;
      end
      send_transform(it);
    end

    for (int n = 0; n < 1600; n++) begin
      if (n == 530) sender_idle_pct = 80;
      if (n == 1060) sender_idle_pct = 0;
      send_transform(random_transform());
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("trs_model_matrix_compose_core_tb: done, clean");
    end else begin
      $display("trs_model_matrix_compose_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("trs_model_matrix_compose_core_tb: done, errors");
    $finish;
  end
endmodule
